[rtl/core/qnorm_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion normalizer package
// Constants shared by the quaternion normalizer pipeline.
// ----------------------------------------------------------------------------
package qnorm_pkg;

    localparam int QN_LANES     = 4;
    localparam int QN_ITERS     = 16;
    localparam int QN_FRAC_BITS = 15;
    localparam int QN_T_SHIFT   = 32;
    localparam int QN_PRE_STAGES = 4;
    localparam int QN_STAGES    = QN_PRE_STAGES + QN_ITERS + 1;

    localparam logic [QN_FRAC_BITS-1:0] QN_OUT_MAX = {QN_FRAC_BITS{1'b1}};

    typedef logic [QN_LANES-1:0] qn_sign_t;
    typedef logic [QN_ITERS-1:0] qn_quot_t;

endpackage

[rtl/core/quaternion_normalizer.sv]
// ----------------------------------------------------------------------------
// Quaternion normalizer
// Scales a quaternion to unit length in Q1.15 with w made non-negative.
// ----------------------------------------------------------------------------
// The block takes one quaternion word per cycle whenever in_ready is high and
// returns its normalized form from the final stage. Four stages take
// magnitudes, squares, the sum of squares and the initial remainders; sixteen
// stages then run a restoring search that settles one result bit per stage
// for all four components at once using only shifts and adds; a final stage
// saturates, applies the sign and substitutes the identity for a zero-length
// input. Each stage holds its word until the next stage frees up, so empty
// stages fill while the output waits.
module quaternion_normalizer
    import qnorm_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  in_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [QN_FRAC_BITS-1:0]     out_w,
    output logic signed [QN_FRAC_BITS:0]       out_x,
    output logic signed [QN_FRAC_BITS:0]       out_y,
    output logic signed [QN_FRAC_BITS:0]       out_z,
    output logic                               zero_length
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int QW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int RW = 2 * W + QN_T_SHIFT + 5;
    localparam int LAST = QN_STAGES - 1;

    logic [QN_STAGES-1:0] valid_reg;
    logic [QN_STAGES-1:0] en;

    logic signed [W-1:0] comp [QN_LANES];

    logic [W-1:0]  mag1_next [QN_LANES];
    qn_sign_t      neg1_next;
    logic [W-1:0]  mag1_reg  [QN_LANES];
    qn_sign_t      neg1_reg;

    logic [QW-1:0] sq2_reg   [QN_LANES];
    qn_sign_t      neg2_reg;

    logic [SW-1:0] sum3_next;
    logic [QW-1:0] sq3_reg   [QN_LANES];
    logic [SW-1:0] sum3_reg;
    qn_sign_t      neg3_reg;

    logic signed [RW-1:0] rem_reg  [QN_ITERS+1][QN_LANES];
    logic signed [RW-1:0] prod_reg [QN_ITERS+1][QN_LANES];
    qn_quot_t             q_reg    [QN_ITERS+1][QN_LANES];
    logic [SW-1:0]        sum_reg  [QN_ITERS+1];
    qn_sign_t             neg_reg  [QN_ITERS+1];

    logic signed [RW-1:0] sum0_ext;
    logic signed [RW-1:0] rem0_next [QN_LANES];

    logic [QN_FRAC_BITS-1:0]   sat_q   [QN_LANES];
    logic signed [QN_FRAC_BITS:0] signed_q [QN_LANES];
    logic [QN_FRAC_BITS-1:0]   out_w_next;
    logic signed [QN_FRAC_BITS:0] out_x_next;
    logic signed [QN_FRAC_BITS:0] out_y_next;
    logic signed [QN_FRAC_BITS:0] out_z_next;
    logic                      zero_next;

    logic [QN_FRAC_BITS-1:0]   out_w_reg;
    logic signed [QN_FRAC_BITS:0] out_x_reg;
    logic signed [QN_FRAC_BITS:0] out_y_reg;
    logic signed [QN_FRAC_BITS:0] out_z_reg;
    logic                      zero_reg;

    // A stage may load when it is empty or when the stage after it loads.
    assign en[LAST] = !valid_reg[LAST] || out_ready;
    for (genvar k = 0; k < LAST; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            for (int k = 0; k < QN_STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign comp[0] = in_w;
    assign comp[1] = in_x;
    assign comp[2] = in_y;
    assign comp[3] = in_z;

    always_comb
    begin
        for (int l = 0; l < QN_LANES; l++) begin
            neg1_next[l] = comp[l][W-1];
            mag1_next[l] = comp[l][W-1] ? W'(-comp[l]) : W'(comp[l]);
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en[1]) begin
            for (int l = 0; l < QN_LANES; l++) begin
                sq2_reg[l] <= QW'(mag1_reg[l]) * QW'(mag1_reg[l]);
            end
            neg2_reg <= neg1_reg;
        end
    end

    assign sum3_next = SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]) + SW'(sq2_reg[3]);

    always_ff @(posedge clk) begin
        if (en[2]) begin
            sq3_reg  <= sq2_reg;
            sum3_reg <= sum3_next;
            neg3_reg <= neg2_reg;
        end
    end

    // The search starts from an odd multiplier of minus one, so the
    // remainder begins at the scaled square minus the sum of squares.
    assign sum0_ext = signed'({{(RW-SW){1'b0}}, sum3_reg});

    always_comb
    begin
        for (int l = 0; l < QN_LANES; l++) begin
            rem0_next[l] = (signed'({{(RW-QW){1'b0}}, sq3_reg[l]}) <<< QN_T_SHIFT) - sum0_ext;
        end
    end

    always_ff @(posedge clk) begin
        if (en[3]) begin
            for (int l = 0; l < QN_LANES; l++) begin
                rem_reg[0][l]  <= rem0_next[l];
                prod_reg[0][l] <= -sum0_ext;
                q_reg[0][l]    <= '0;
            end
            sum_reg[0] <= sum3_reg;
            neg_reg[0] <= neg3_reg;
        end
    end

    // Each stage tries one more result bit. The remainder tracks
    // 2^32 * a^2 - (2q-1)^2 * s and the product tracks (2q-1) * s.
    for (genvar t = 1; t <= QN_ITERS; t++) begin : g_iter
        localparam int B = QN_ITERS - t;

        logic signed [RW-1:0] sum_ext;
        logic signed [RW-1:0] trial_next [QN_LANES];
        logic signed [RW-1:0] rem_next   [QN_LANES];
        logic signed [RW-1:0] prod_next  [QN_LANES];
        qn_quot_t             q_next     [QN_LANES];

        assign sum_ext = signed'({{(RW-SW){1'b0}}, sum_reg[t-1]});

        always_comb
        begin
            for (int l = 0; l < QN_LANES; l++) begin
                trial_next[l] = rem_reg[t-1][l]
                              - ((prod_reg[t-1][l] + (sum_ext <<< B)) <<< (B + 2));
                rem_next[l]   = rem_reg[t-1][l];
                prod_next[l]  = prod_reg[t-1][l];
                q_next[l]     = q_reg[t-1][l];
                if (!q_reg[t-1][l][QN_ITERS-1] && !trial_next[l][RW-1]) begin
                    rem_next[l]  = trial_next[l];
                    prod_next[l] = prod_reg[t-1][l] + (sum_ext <<< (B + 1));
                    q_next[l]    = q_reg[t-1][l] | (qn_quot_t'(1) << B);
                end
            end
        end

        always_ff @(posedge clk) begin
            if (en[QN_PRE_STAGES - 1 + t]) begin
                rem_reg[t]  <= rem_next;
                prod_reg[t] <= prod_next;
                q_reg[t]    <= q_next;
                sum_reg[t]  <= sum_reg[t-1];
                neg_reg[t]  <= neg_reg[t-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < QN_LANES; l++) begin
            sat_q[l] = q_reg[QN_ITERS][l][QN_ITERS-1] ? QN_OUT_MAX
                                                      : q_reg[QN_ITERS][l][QN_FRAC_BITS-1:0];
            if ((neg_reg[QN_ITERS][l] != neg_reg[QN_ITERS][0]) && (sat_q[l] != '0)) begin
                signed_q[l] = -signed'({1'b0, sat_q[l]});
            end
            else begin
                signed_q[l] = signed'({1'b0, sat_q[l]});
            end
        end

        zero_next = (sum_reg[QN_ITERS] == '0);
        if (zero_next) begin
            out_w_next = QN_OUT_MAX;
            out_x_next = '0;
            out_y_next = '0;
            out_z_next = '0;
        end
        else begin
            out_w_next = sat_q[0];
            out_x_next = signed_q[1];
            out_y_next = signed_q[2];
            out_z_next = signed_q[3];
        end
    end

    always_ff @(posedge clk) begin
        if (en[LAST]) begin
            out_w_reg <= out_w_next;
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
            zero_reg  <= zero_next;
        end
    end

    assign out_w       = out_w_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign zero_length = zero_reg;

endmodule
